>>> sv/tlsu_pkg.sv
// Package: operation codes and shared types for the Thumb load/store unit.
package tlsu_pkg;
    typedef enum logic [4:0] {
        OP_LDM = 5'd0, OP_STM = 5'd1, OP_POP = 5'd2, OP_PUSH = 5'd3,
        OP_LDR_IMM = 5'd4, OP_LDR_SP = 5'd5, OP_LDR_LIT = 5'd6, OP_LDR_REG = 5'd7,
        OP_LDRB_IMM = 5'd8, OP_LDRB_REG = 5'd9, OP_LDRH_IMM = 5'd10, OP_LDRH_REG = 5'd11,
        OP_LDRSB_REG = 5'd12, OP_LDRSH_REG = 5'd13,
        OP_STR_IMM = 5'd14, OP_STR_SP = 5'd15, OP_STR_REG = 5'd16,
        OP_STRB_IMM = 5'd17, OP_STRB_REG = 5'd18, OP_STRH_IMM = 5'd19, OP_STRH_REG = 5'd20
    } t_op;

    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_LR = 4'd14;
    localparam logic CFG_MEM_CYCLES = 1'b0;
    localparam logic CFG_PC_CYCLES  = 1'b1;
endpackage

>>> sv/tlsu_ram.sv
// Generic single-port RAM with registered read.
module tlsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> sv/thumb_load_store_unit_core.sv
// Top level: Thumb load/store unit with register file and data memory.
// Usage:
//   An instruction word is taken when i_start is high and o_busy is low.
//   o_done pulses for one cycle with o_cycles, o_branch_taken, o_new_pc and
//   o_malformed; the receiver must take it then, it cannot stall.
//   Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index, i_cfg_data;
//   index 0 mem_cycles, index 1 pc_update_cycles. Write only while idle.
// Sequence: one shared address adder and one memory port are reused per
//   transfer. o_busy stays high from acceptance: loads and sub-word stores
//   pass S_ADDR, S_MREQ, S_MWAIT, S_MDATA, S_DONE; word stores S_ADDR,
//   S_MREQ, S_DONE; LDM/POP S_ADDR, S_LIST with S_LREQ and S_LWAIT per
//   word, S_WBACK, S_DONE; STM/PUSH the same without S_LWAIT. Undefined
//   codes and malformed STM pass S_ADDR and S_DONE.
//   o_done comes in the first idle cycle, where the next word can be taken.
// Reset:
//   Registers clear at once. The data memory is then cleared by a pass over
//   all MEM_WORDS words, one word a cycle, during which o_busy stays high.
//   Configuration writes are taken during that pass.
module thumb_load_store_unit_core
    import tlsu_pkg::*;
#(
    parameter int MEM_WORDS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [4:0]  i_mode,
    input  logic [2:0]  i_dest_reg,
    input  logic [2:0]  i_base_reg,
    input  logic [2:0]  i_offset_reg,
    input  logic [7:0]  i_immediate,
    input  logic [15:0] i_register_list,
    input  logic [31:0] i_pc_value,
    output logic        o_done,
    output logic [4:0]  o_cycles,
    output logic        o_branch_taken,
    output logic [31:0] o_new_pc,
    output logic        o_malformed,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    localparam int AW = $clog2(MEM_WORDS);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ADDR, S_MREQ, S_MWAIT, S_MDATA, S_LIST, S_LREQ, S_LWAIT,
        S_WBACK, S_DONE
    } t_state;

    t_state      r_state;
    logic [AW:0] r_clr;
    logic [31:0] r_regs [15];
    logic [3:0]  r_mem_cyc, r_pc_cyc;
    t_op         r_op;
    logic [2:0]  r_rd, r_rn, r_rm;
    logic [7:0]  r_imm;
    logic [15:0] r_list;
    logic [31:0] r_pc, r_addr;
    logic [3:0]  r_cur;
    logic [4:0]  r_cnt;
    logic        r_taken, r_bad;
    logic [31:0] r_newpc;
    // ldm base-in-list test uses the list as accepted
    logic [7:0]  r_orig;

    logic          m_we;
    logic [AW-1:0] m_addr;
    logic [31:0]   m_wdata, m_rdata;

    tlsu_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
        .i_clk(i_clk), .i_we(m_we), .i_addr(m_addr), .i_wdata(m_wdata), .o_rdata(m_rdata)
    );

    function automatic logic [31:0] rdr(input logic [31:0] regs [15], input logic [3:0] r);
        rdr = (r < 4'd15) ? regs[r] : 32'd0;
    endfunction

    // shared adder operands
    logic [31:0] a_op, b_op, sum;
    logic        is_ld, is_byte, is_half, is_multi;
    logic [3:0]  first_bit;
    always_comb begin
        is_multi = (r_op == OP_LDM) || (r_op == OP_STM) || (r_op == OP_POP) || (r_op == OP_PUSH);
        is_ld = (r_op >= OP_LDR_IMM) && (r_op <= OP_LDRSH_REG);
        is_byte = (r_op == OP_LDRB_IMM) || (r_op == OP_LDRB_REG) || (r_op == OP_LDRSB_REG)
               || (r_op == OP_STRB_IMM) || (r_op == OP_STRB_REG);
        is_half = (r_op == OP_LDRH_IMM) || (r_op == OP_LDRH_REG) || (r_op == OP_LDRSH_REG)
               || (r_op == OP_STRH_IMM) || (r_op == OP_STRH_REG);
        a_op = rdr(r_regs, {1'b0, r_rn});
        b_op = rdr(r_regs, {1'b0, r_rm});
        unique case (r_op)
            OP_LDR_IMM, OP_STR_IMM: b_op = {22'd0, r_imm, 2'b00};
            OP_LDR_SP, OP_STR_SP: begin
                a_op = rdr(r_regs, REG_SP);
                b_op = {22'd0, r_imm, 2'b00};
            end
            OP_LDR_LIT: begin
                a_op = {r_pc[31:2], 2'b00};
                b_op = {22'd0, r_imm, 2'b00};
            end
            OP_LDRB_IMM, OP_STRB_IMM: b_op = {24'd0, r_imm};
            OP_LDRH_IMM, OP_STRH_IMM: b_op = {23'd0, r_imm, 1'b0};
            OP_LDR_REG, OP_LDRB_REG, OP_LDRH_REG, OP_LDRSB_REG, OP_LDRSH_REG,
            OP_STR_REG, OP_STRB_REG, OP_STRH_REG: ;
            OP_PUSH: begin
                a_op = r_addr;
                b_op = 32'hFFFF_FFFC;
            end
            default: begin
                a_op = r_addr;
                b_op = 32'd4;
            end
        endcase
        sum = a_op + b_op;
        first_bit = 4'd8;
        for (int k = 7; k >= 0; k--) begin
            if (r_list[k]) first_bit = 4'(k);
        end
    end

    // next list element to transfer
    logic [3:0] nxt;
    logic       have;
    always_comb begin
        nxt = 4'd0;
        have = 1'b0;
        if (r_op == OP_PUSH) begin
            if (r_list[14]) begin
                nxt = REG_LR; have = 1'b1;
            end else begin
                for (int k = 0; k < 8; k++) begin
                    if (r_list[k]) begin nxt = 4'(k); have = 1'b1; end
                end
            end
        end else begin
            for (int k = 7; k >= 0; k--) begin
                if (r_list[k]) begin nxt = 4'(k); have = 1'b1; end
            end
            if (!have && r_op == OP_POP && r_list[15]) begin
                nxt = 4'd15; have = 1'b1;
            end
        end
    end

    logic [31:0] ld_val, st_val, old_w;
    logic [4:0]  sh;
    logic [31:0] src;
    always_comb begin
        sh = {r_addr[1:0], 3'b000};
        if (is_half) sh = {r_addr[1], 4'b0000};
        old_w = m_rdata >> sh;
        unique case (r_op)
            OP_LDRB_IMM, OP_LDRB_REG: ld_val = {24'd0, old_w[7:0]};
            OP_LDRSB_REG: ld_val = {{24{old_w[7]}}, old_w[7:0]};
            OP_LDRH_IMM, OP_LDRH_REG: ld_val = {16'd0, old_w[15:0]};
            OP_LDRSH_REG: ld_val = {{16{old_w[15]}}, old_w[15:0]};
            default: ld_val = m_rdata;
        endcase
        src = rdr(r_regs, {1'b0, r_rd});
        if (is_byte) st_val = (m_rdata & ~(32'hFF << sh)) | ({24'd0, src[7:0]} << sh);
        else st_val = (m_rdata & ~(32'hFFFF << sh)) | ({16'd0, src[15:0]} << sh);
    end

    always_comb begin
        m_we = 1'b0;
        m_addr = r_addr[AW+1:2];
        m_wdata = st_val;
        if (r_state == S_CLEAR) begin
            m_we = 1'b1; m_addr = r_clr[AW-1:0]; m_wdata = 32'd0;
        end else if (r_state == S_MREQ && !is_ld && !is_byte && !is_half) begin
            m_we = 1'b1; m_wdata = src;
        end else if (r_state == S_MDATA && !is_ld) begin
            m_we = 1'b1;
        end else if (r_state == S_LREQ && (r_op == OP_STM || r_op == OP_PUSH)) begin
            m_we = 1'b1; m_wdata = rdr(r_regs, r_cur);
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) r_orig <= i_register_list[7:0];
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            for (int k = 0; k < 15; k++) r_regs[k] <= 32'd0;
            r_mem_cyc <= 4'd2;
            r_pc_cyc <= 4'd3;
            o_done <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_MEM_CYCLES) r_mem_cyc <= i_cfg_data;
                else r_pc_cyc <= i_cfg_data;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(MEM_WORDS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_start) begin
                    r_op <= t_op'(i_mode);
                    r_rd <= i_dest_reg; r_rn <= i_base_reg; r_rm <= i_offset_reg;
                    r_imm <= i_immediate; r_list <= i_register_list; r_pc <= i_pc_value;
                    r_taken <= 1'b0; r_bad <= 1'b0; r_newpc <= 32'd0; r_cnt <= 5'd1;
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    if (r_op > OP_STRH_REG) begin
                        r_cnt <= 5'd0; r_state <= S_DONE;
                    end else if (is_multi) begin
                        r_list <= (r_op == OP_POP) ? {r_list[15], 7'd0, r_list[7:0]}
                                : (r_op == OP_PUSH) ? {1'b0, r_list[14], 6'd0, r_list[7:0]}
                                : {8'd0, r_list[7:0]};
                        r_addr <= (r_op == OP_POP || r_op == OP_PUSH)
                                ? rdr(r_regs, REG_SP) : rdr(r_regs, {1'b0, r_rn});
                        if (r_op == OP_STM && first_bit == {1'b0, r_rn}) begin
                            r_bad <= 1'b1; r_cnt <= 5'd0; r_state <= S_DONE;
                        end else begin
                            r_state <= S_LIST;
                        end
                    end else begin
                        r_addr <= sum;
                        r_cnt <= {1'b0, r_mem_cyc};
                        r_state <= S_MREQ;
                    end
                end
                S_MREQ: r_state <= (!is_ld && !is_byte && !is_half) ? S_DONE : S_MWAIT;
                S_MWAIT: r_state <= S_MDATA;
                S_MDATA: begin
                    if (is_ld) r_regs[r_rd] <= ld_val;
                    r_state <= S_DONE;
                end
                S_LIST: begin
                    if (have) begin
                        r_cur <= nxt;
                        r_list[nxt] <= 1'b0;
                        if (r_op == OP_PUSH) r_addr <= sum;
                        r_state <= S_LREQ;
                    end else begin
                        r_state <= S_WBACK;
                    end
                end
                S_LREQ: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_op == OP_PUSH) r_state <= S_LIST;
                    else if (r_op == OP_STM) begin
                        r_addr <= sum; r_state <= S_LIST;
                    end else r_state <= S_LWAIT;
                end
                S_LWAIT: begin
                    if (r_cur == 4'd15) begin
                        r_newpc <= m_rdata; r_taken <= 1'b1;
                        r_cnt <= r_cnt + {1'b0, r_pc_cyc};
                    end else begin
                        r_regs[r_cur] <= m_rdata;
                    end
                    r_addr <= sum;
                    r_state <= S_LIST;
                end
                S_WBACK: begin
                    if (r_op == OP_POP || r_op == OP_PUSH) r_regs[REG_SP] <= r_addr;
                    else if (!(r_op == OP_LDM && r_orig[r_rn])) r_regs[r_rn] <= r_addr;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    o_done <= 1'b1;
                    o_cycles <= r_cnt;
                    o_branch_taken <= r_taken;
                    o_new_pc <= r_newpc;
                    o_malformed <= r_bad;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_IDLE) else $error("done outside idle");
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_malformed) |-> (o_cycles == 5'd0)) else $error("malformed cycles");
    a_pc_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_branch_taken) |-> (o_new_pc == 32'd0)) else $error("stray pc");
`endif
endmodule

>>> test/tb.sv
// Testbench for the Thumb load/store unit: directed and random instruction words checked by a predictor.
`timescale 1ns / 100ps
module tb;
    import tlsu_pkg::*;

    localparam int MEM_WORDS = 4096;

    typedef struct packed {
        logic [4:0]  cycles;
        logic        branch_taken;
        logic [31:0] new_pc;
        logic        malformed;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [4:0]  i_mode = '0;
    logic [2:0]  i_dest_reg = '0;
    logic [2:0]  i_base_reg = '0;
    logic [2:0]  i_offset_reg = '0;
    logic [7:0]  i_immediate = '0;
    logic [15:0] i_register_list = '0;
    logic [31:0] i_pc_value = '0;
    logic        o_done;
    logic [4:0]  o_cycles;
    logic        o_branch_taken;
    logic [31:0] o_new_pc;
    logic        o_malformed;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [3:0]  i_cfg_data = '0;

    logic [31:0] regs [15];
    logic [31:0] mem [MEM_WORDS];
    logic [3:0]  mem_cyc;
    logic [3:0]  pc_cyc;
    t_outcome    outcome_q[$];
    int          errors = 0;

    thumb_load_store_unit_core #(.MEM_WORDS(MEM_WORDS)) dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic int widx(logic [31:0] a);
        return int'(a[31:2] % MEM_WORDS);
    endfunction

    function automatic t_outcome execute(logic [4:0] mode, logic [2:0] rdi, logic [2:0] rn,
                                         logic [2:0] rm, logic [7:0] imm, logic [15:0] list,
                                         logic [31:0] pc);
        t_outcome o;
        logic [31:0] addr, v;
        int n, first, sh;
        o = '0;
        n = 0;
        case (mode)
            OP_LDM: begin
                addr = regs[rn];
                for (int i = 0; i < 8; i++) if (list[i]) begin
                    regs[i] = mem[widx(addr)]; addr += 4; n++;
                end
                if (!list[rn]) regs[rn] = addr;
                o.cycles = 5'(1 + n);
            end
            OP_STM: begin
                first = 8;
                for (int i = 7; i >= 0; i--) if (list[i]) first = i;
                if (first == int'(rn)) begin
                    o.malformed = 1'b1;
                end else begin
                    addr = regs[rn];
                    for (int i = 0; i < 8; i++) if (list[i]) begin
                        mem[widx(addr)] = regs[i]; addr += 4; n++;
                    end
                    regs[rn] = addr;
                    o.cycles = 5'(1 + n);
                end
            end
            OP_POP: begin
                addr = regs[REG_SP];
                for (int i = 0; i < 8; i++) if (list[i]) begin
                    regs[i] = mem[widx(addr)]; addr += 4; n++;
                end
                if (list[15]) begin
                    o.new_pc = mem[widx(addr)]; o.branch_taken = 1'b1; addr += 4; n++;
                end
                regs[REG_SP] = addr;
                o.cycles = 5'(1 + n + (list[15] ? pc_cyc : 0));
            end
            OP_PUSH: begin
                addr = regs[REG_SP];
                if (list[14]) begin
                    addr -= 4; mem[widx(addr)] = regs[REG_LR]; n++;
                end
                for (int i = 7; i >= 0; i--) if (list[i]) begin
                    addr -= 4; mem[widx(addr)] = regs[i]; n++;
                end
                regs[REG_SP] = addr;
                o.cycles = 5'(1 + n);
            end
            OP_LDR_IMM: regs[rdi] = mem[widx(regs[rn] + {imm, 2'b0})];
            OP_LDR_SP:  regs[rdi] = mem[widx(regs[REG_SP] + {imm, 2'b0})];
            OP_LDR_LIT: regs[rdi] = mem[widx({pc[31:2], 2'b0} + {imm, 2'b0})];
            OP_LDR_REG: regs[rdi] = mem[widx(regs[rn] + regs[rm])];
            OP_LDRB_IMM, OP_LDRB_REG, OP_LDRH_IMM, OP_LDRH_REG, OP_LDRSB_REG,
            OP_LDRSH_REG: begin
                addr = regs[rn] + (mode == OP_LDRB_IMM ? 32'(imm) :
                       mode == OP_LDRH_IMM ? 32'({imm, 1'b0}) : regs[rm]);
                v = mem[widx(addr)];
                if (mode == OP_LDRB_IMM || mode == OP_LDRB_REG || mode == OP_LDRSB_REG) begin
                    v = (v >> (addr[1:0] * 8)) & 32'hFF;
                    if (mode == OP_LDRSB_REG && v[7]) v |= 32'hFFFFFF00;
                end else begin
                    v = (v >> (addr[1] * 16)) & 32'hFFFF;
                    if (mode == OP_LDRSH_REG && v[15]) v |= 32'hFFFF0000;
                end
                regs[rdi] = v;
            end
            OP_STR_IMM: mem[widx(regs[rn] + {imm, 2'b0})] = regs[rdi];
            OP_STR_SP:  mem[widx(regs[REG_SP] + {imm, 2'b0})] = regs[rdi];
            OP_STR_REG: mem[widx(regs[rn] + regs[rm])] = regs[rdi];
            OP_STRB_IMM, OP_STRB_REG: begin
                addr = regs[rn] + (mode == OP_STRB_IMM ? 32'(imm) : regs[rm]);
                sh = addr[1:0] * 8;
                v = mem[widx(addr)];
                v = (v & ~(32'hFF << sh)) | ((regs[rdi] & 32'hFF) << sh);
                mem[widx(addr)] = v;
            end
            OP_STRH_IMM, OP_STRH_REG: begin
                addr = regs[rn] + (mode == OP_STRH_IMM ? 32'({imm, 1'b0}) : regs[rm]);
                sh = addr[1] * 16;
                v = mem[widx(addr)];
                v = (v & ~(32'hFFFF << sh)) | ((regs[rdi] & 32'hFFFF) << sh);
                mem[widx(addr)] = v;
            end
            default: ;
        endcase
        if (mode >= OP_LDR_IMM && mode <= OP_STRH_REG) o.cycles = 5'(mem_cyc);
        return o;
    endfunction

    task automatic send_word(logic [4:0] mode, logic [2:0] rdi, logic [2:0] rn,
                             logic [2:0] rm, logic [7:0] imm, logic [15:0] list,
                             logic [31:0] pc, bit gaps = 1);
        int r;
        int len;
        len = 0;
        if (gaps) begin
            r = $urandom_range(0, 99);
            if (r >= 40) len = r < 92 ? $urandom_range(1, 3) : $urandom_range(5, 40);
        end
        if (len > 0) begin
            i_start <= 1'b0;
            repeat (len) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_mode <= mode;
        i_dest_reg <= rdi;
        i_base_reg <= rn;
        i_offset_reg <= rm;
        i_immediate <= imm;
        i_register_list <= list;
        i_pc_value <= pc;
        do @(posedge i_clk); while (o_busy);
        outcome_q.push_back(execute(mode, rdi, rn, rm, imm, list, pc));
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (outcome_q.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                want = outcome_q.pop_front();
                if (o_cycles !== want.cycles) begin
                    $error("cycles exp %0d got %0d", want.cycles, o_cycles); errors++;
                end
                if (o_branch_taken !== want.branch_taken) begin
                    $error("branch_taken exp %0d got %0d", want.branch_taken, o_branch_taken);
                    errors++;
                end
                if (o_new_pc !== want.new_pc) begin
                    $error("new_pc exp %h got %h", want.new_pc, o_new_pc); errors++;
                end
                if (o_malformed !== want.malformed) begin
                    $error("malformed exp %0d got %0d", want.malformed, o_malformed); errors++;
                end
            end
        end
    end

    task automatic drain();
        i_start <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [3:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_MEM_CYCLES) mem_cyc = val; else pc_cyc = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic rand_word(int mix);
        logic [4:0] mode;
        logic [15:0] list;
        mode = $urandom_range(0, 99) < 3 ? 5'($urandom_range(21, 31)) : 5'($urandom_range(0, 20));
        list = 16'($urandom());
        if (mix == 0 && $urandom_range(0, 1)) list = list & 16'hC0FF & ~(16'h1 << $urandom_range(0, 7));
        send_word(mode, 3'($urandom()), 3'($urandom()), 3'($urandom()), 8'($urandom()), list,
                  $urandom());
    endtask

    task automatic test_directed();
        send_word(OP_STM, 3'd0, 3'd0, 3'd0, 8'd0, 16'h0000, 32'd0);
        send_word(OP_LDM, 3'd0, 3'd0, 3'd0, 8'd0, 16'h0000, 32'd0);
        send_word(OP_LDR_LIT, 3'd7, 3'd0, 3'd0, 8'd255, 16'h0, 32'hFFFFFFFF);
        send_word(OP_STR_SP, 3'd7, 3'd0, 3'd0, 8'd255, 16'h0, 32'h0);
        send_word(OP_PUSH, 3'd0, 3'd0, 3'd0, 8'd0, 16'hFFFF, 32'h0);
        send_word(OP_POP, 3'd0, 3'd0, 3'd0, 8'd0, 16'hFFFF, 32'h0);
        send_word(OP_STM, 3'd0, 3'd2, 3'd0, 8'd0, 16'h00FC, 32'h0);
        send_word(OP_STM, 3'd0, 3'd2, 3'd0, 8'd0, 16'hFF0A, 32'h0);
        send_word(OP_LDM, 3'd0, 3'd1, 3'd0, 8'd0, 16'hFF03, 32'h0);
        for (int m = OP_LDR_IMM; m <= OP_STRH_REG; m++)
            send_word(5'(m), 3'(m), 3'(m + 1), 3'(m + 2), 8'(m * 37), 16'h0, 32'(m));
        send_word(5'd31, 3'd7, 3'd7, 3'd7, 8'hFF, 16'hFFFF, 32'hFFFFFFFF);
        send_word(5'd21, 3'd0, 3'd0, 3'd0, 8'h00, 16'h0, 32'h0);
    endtask

    task automatic test_random_phase(int count, logic [3:0] mc, logic [3:0] pcc);
        drain();
        write_cfg(CFG_MEM_CYCLES, mc);
        write_cfg(CFG_PC_CYCLES, pcc);
        for (int k = 0; k < count; k++) begin
            if (k == count / 2) drain();
            rand_word(k % 3);
        end
    endtask

    task automatic test_back_to_back();
        for (int k = 0; k < 150; k++)
            send_word(5'($urandom_range(0, 20)), 3'($urandom()), 3'($urandom()),
                      3'($urandom()), 8'($urandom()), 16'($urandom()), $urandom(), 1'b0);
    endtask

    initial begin
        for (int i = 0; i < 15; i++) regs[i] = '0;
        for (int i = 0; i < MEM_WORDS; i++) mem[i] = '0;
        mem_cyc = 4'd2;
        pc_cyc = 4'd3;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_phase(400, 4'd1, 4'd0);
        test_random_phase(400, 4'd15, 4'd15);
        test_random_phase(300, 4'd0, 4'd7);
        test_back_to_back();
        test_random_phase(400, 4'd5, 4'd1);
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("status: fail");
        $finish;
    end
endmodule
